>>> rtl/rakt_pkg.sv
// ----------------------------------------------------------------------------
// rakt_pkg
// Shared types and codes of the reference-count aging key table.
// ----------------------------------------------------------------------------
package rakt_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned REFS_W = 16;
  localparam int unsigned MARK_W = 7;
  localparam int unsigned CNT_W  = 7;
  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  // Configuration register indexes
  localparam logic CFG_HIGH_MARK = 1'b0;
  localparam logic CFG_LOW_MARK  = 1'b1;

  // Item kinds on the input tuser
  localparam logic MODE_REF   = 1'b0;
  localparam logic MODE_CLEAN = 1'b1;

  typedef enum logic [2:0] {
    STAT_HIT      = 3'd0,
    STAT_INSERTED = 3'd1,
    STAT_REFUSED  = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_CLEANED  = 3'd4,
    STAT_SKIPPED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [REFS_W-1:0] refs;
    logic [KEY_W-1:0]  key;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;   // clearing pass, one entry a cycle
    logic start;   // input transfer taken this cycle
    logic walk;    // table walk running
    logic finish;  // load result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic early;      // refused or skipped without a walk
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/rakt_ctrl.sv
// ----------------------------------------------------------------------------
// rakt_ctrl
// Sequencer: clearing pass after reset, item accept, table walk, result load.
// ----------------------------------------------------------------------------
module rakt_ctrl
  import rakt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) state_d = sts_i.early ? S_FINISH : S_WALK;
      end
      S_WALK: begin
        if (sts_i.walk_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      S_CLEAR:  cmd_o.clear = 1'b1;
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.start     = s_axis_tvalid_i;
      end
      S_WALK:   cmd_o.walk = 1'b1;
      S_FINISH: cmd_o.finish = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

>>> rtl/rakt_dp.sv
// ----------------------------------------------------------------------------
// rakt_dp
// Datapath: entry memory, walk counter, lookup/clean stage, marks, result.
// ----------------------------------------------------------------------------
module rakt_dp
  import rakt_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [MARK_W-1:0] cfg_wdata_i,
  input  logic [39:0]       s_axis_tdata_i,
  input  logic              s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [15:0]       m_axis_tdata_o,
  output logic [2:0]        m_axis_tuser_o,
  input  cmd_t              cmd_i,
  output sts_t              sts_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (LW > MARK_W) ? LW : MARK_W;
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  entry_t mem [CAPACITY];

  logic [MARK_W-1:0] hwm_q, lwm_q;
  logic [LW-1:0]     live_q, live_d;
  logic              mode_q;
  logic [KEY_W-1:0]  key_q;
  logic [AW-1:0]     addr_q, addr_d;
  logic              issue_q, issue_d;
  logic              rd_vld_q;
  logic [AW-1:0]     rd_addr_q;
  entry_t            rd_data_q;
  logic              free_found_q, free_found_d;
  logic [AW-1:0]     free_slot_q, free_slot_d;
  logic [LW-1:0]     removed_q, removed_d;
  status_e           status_q, status_d;
  logic [LW-1:0]     evicted_q, evicted_d;
  logic              out_valid_q;
  status_e           out_status_q;
  logic [CNT_W-1:0]  out_count_q, out_evicted_q;

  logic              in_mode, in_check;
  logic [KEY_W-1:0]  in_key;
  logic              refuse, skip;
  logic              stage, hit, at_last, is_free, evict;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;

  assign in_key   = s_axis_tdata_i[KEY_W-1:0];
  assign in_check = s_axis_tdata_i[KEY_W];
  assign in_mode  = s_axis_tuser_i;

  assign refuse = (in_mode == MODE_REF) && (CW'(live_q) > CW'(hwm_q));
  assign skip   = (in_mode == MODE_CLEAN) && in_check && (CW'(live_q) < CW'(lwm_q));

  assign stage   = cmd_i.walk && rd_vld_q;
  assign at_last = (rd_addr_q == LAST);
  assign hit     = (mode_q == MODE_REF) && rd_data_q.valid && (rd_data_q.key == key_q);
  assign is_free = !rd_data_q.valid;
  assign evict   = rd_data_q.valid && (rd_data_q.refs <= REFS_W'(1));

  assign sts_o.clear_last = cmd_i.clear && (addr_q == LAST);
  assign sts_o.early      = refuse || skip;
  assign sts_o.walk_done  = stage && (hit || at_last);
  assign sts_o.out_free   = !out_valid_q || m_axis_tready_i;

  // walk counter and item state
  always_comb begin
    addr_d       = addr_q;
    issue_d      = issue_q;
    free_found_d = free_found_q;
    free_slot_d  = free_slot_q;
    removed_d    = removed_q;
    status_d     = status_q;
    evicted_d    = evicted_q;
    live_d       = live_q;
    wr_en        = 1'b0;
    wr_addr      = rd_addr_q;
    wr_data      = rd_data_q;

    if (cmd_i.clear) begin
      addr_d  = addr_q + AW'(1);
      wr_en   = 1'b1;
      wr_addr = addr_q;
      wr_data = '0;
    end

    if (cmd_i.start) begin
      addr_d       = '0;
      issue_d      = 1'b1;
      free_found_d = 1'b0;
      removed_d    = '0;
      evicted_d    = '0;
      status_d     = refuse ? STAT_REFUSED : STAT_SKIPPED;
    end

    if (cmd_i.walk) begin
      addr_d = addr_q + AW'(1);
      if (addr_q == LAST) issue_d = 1'b0;
    end

    if (stage) begin
      if (mode_q == MODE_REF) begin
        if (hit) begin
          wr_en        = 1'b1;
          wr_data.refs = (rd_data_q.refs == REFS_MAX) ? REFS_MAX
                                                       : rd_data_q.refs + REFS_W'(1);
          status_d     = STAT_HIT;
        end else begin
          if (is_free && !free_found_q) begin
            free_found_d = 1'b1;
            free_slot_d  = rd_addr_q;
          end
          if (at_last) begin
            if (free_found_d) begin
              wr_en    = 1'b1;
              wr_addr  = free_slot_d;
              wr_data  = '{valid: 1'b1, refs: REFS_W'(1), key: key_q};
              live_d   = live_q + LW'(1);
              status_d = STAT_INSERTED;
            end else begin
              status_d = STAT_FULL;
            end
          end
        end
      end else begin
        if (rd_data_q.valid) begin
          wr_en = 1'b1;
          if (evict) begin
            wr_data   = '0;
            removed_d = removed_q + LW'(1);
          end else begin
            wr_data.refs = rd_data_q.refs - REFS_W'(1);
          end
        end
        if (at_last) begin
          live_d    = live_q - removed_d;
          evicted_d = removed_d;
          status_d  = STAT_CLEANED;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hwm_q       <= MARK_W'(48);
      lwm_q       <= MARK_W'(16);
      live_q      <= '0;
      addr_q      <= '0;
      issue_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HIGH_MARK: hwm_q <= cfg_wdata_i;
          CFG_LOW_MARK:  lwm_q <= cfg_wdata_i;
          default:       hwm_q <= hwm_q;
        endcase
      end
      live_q   <= live_d;
      addr_q   <= addr_d;
      issue_q  <= issue_d;
      rd_vld_q <= cmd_i.walk && issue_q;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q <= in_mode;
      key_q  <= in_key;
    end
    rd_addr_q    <= addr_q;
    free_found_q <= free_found_d;
    free_slot_q  <= free_slot_d;
    removed_q    <= removed_d;
    status_q     <= status_d;
    evicted_q    <= evicted_d;
    if (cmd_i.finish) begin
      out_status_q  <= status_q;
      out_count_q   <= CNT_W'(live_q);
      out_evicted_q <= CNT_W'(evicted_q);
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_q <= mem[addr_q];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_evicted_q, out_count_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule

>>> rtl/refcount_aging_key_table.sv
// ----------------------------------------------------------------------------
// refcount_aging_key_table
// Key table with saturating reference counts, aging clean pass and marks.
//
//   channel   dir  transfer              payload
//   s_axis    in   tvalid & tready       tdata: key, check_mark; tuser: mode
//   m_axis    out  tvalid & tready       tdata: entry_count, evicted; tuser: status
//   cfg       in   cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// A clean or a missed reference walks every entry (one memory read per
// entry) before ready rises again; a hit ends the walk at the matching
// entry; a refusal or skip loads its result without a walk. After reset a
// clearing pass over all entries runs with s_axis_tready_o low. One result
// is held in the output register; a stalled output holds the next result in the finish step.
// ----------------------------------------------------------------------------
module refcount_aging_key_table
  import rakt_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [MARK_W-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [39:0]       s_axis_tdata_i,  // key[31:0], check_mark[32], zero
  input  logic              s_axis_tuser_i,  // mode[0]
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [15:0]       m_axis_tdata_o,  // entry_count[6:0], evicted[13:7], zero
  output logic [2:0]        m_axis_tuser_o   // status[2:0]
);

  cmd_t cmd;
  sts_t sts;

  rakt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  rakt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

>>> rtl/rakt_chk.sv
// ----------------------------------------------------------------------------
// rakt_chk
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rakt_chk
  import rakt_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  // stalled result transfer holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o <= STAT_SKIPPED))
    else $error("unknown status code");

  // only a clean pass reports evictions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != STAT_CLEANED) |-> (m_axis_tdata_o[13:7] == '0))
    else $error("evicted set on a non-clean result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (CAPACITY < 128) |-> (32'(m_axis_tdata_o[6:0]) <= CAPACITY))
    else $error("entry count beyond capacity");

endmodule

bind refcount_aging_key_table rakt_chk #(.CAPACITY(CAPACITY)) u_rakt_chk (.*);
